// ===== rtl/accc_pkg.sv =====
// Shared types, constants and character helpers for the aircraft category classifier.
// Used by every module of the block but accc_range_lane. Depends on nothing else.
package accc_pkg;

  localparam int CsLen   = 6;
  localparam int TagMax  = 5;
  localparam int NTags   = 20;
  localparam int NRanges = 5;

  typedef logic [7:0] byte_t;
  typedef byte_t      cs_t [CsLen];

  // Result category codes.
  typedef enum logic [1:0] {
    CAT_MILITARY   = 2'd0,
    CAT_COMMERCIAL = 2'd1,
    CAT_GENERAL    = 2'd2,
    CAT_UNKNOWN    = 2'd3
  } cat_t;

  // Military address ranges, inclusive on both ends.
  localparam logic [23:0] RANGE_LO [NRanges] = '{
    24'hADF7C8, 24'h43C000, 24'h3F8000, 24'h3B7000, 24'hC87F00
  };
  localparam logic [23:0] RANGE_HI [NRanges] = '{
    24'hAFFFFF, 24'h43FFFF, 24'h3FFFFF, 24'h3B7FFF, 24'hC87FFF
  };

  // Military callsign prefixes, first character in the top byte, zero padded.
  localparam logic [8*TagMax-1:0] TAG_TEXT [NTags] = '{
    {"RCH", 16'h0}, {"SAM", 16'h0}, {"PAT", 16'h0}, "SHADO", "KNIFE",
    {"GRIM", 8'h0}, {"SPAR", 8'h0}, {"CNV", 16'h0}, {"VV", 24'h0},
    {"NAVY", 8'h0}, {"MC", 24'h0}, {"ARMY", 8'h0}, {"CG", 24'h0},
    {"RRR", 16'h0}, {"NATO", 8'h0}, "MAGMA", {"CFC", 16'h0}, "HUSKY",
    "COTAM", {"GAF", 16'h0}
  };
  localparam logic [2:0] TAG_LEN [NTags] = '{
    3'd3, 3'd3, 3'd3, 3'd5, 3'd5, 3'd4, 3'd4, 3'd3, 3'd2, 3'd4,
    3'd2, 3'd4, 3'd2, 3'd3, 3'd4, 3'd5, 3'd3, 3'd5, 3'd5, 3'd3
  };

  // Hit flags gathered by the lanes for one item.
  typedef struct packed {
    logic [NRanges-1:0] range_hit;
    logic [NTags-1:0]   tag_hit;
    logic               airline;
    logic               regn;
  } hits_t;

  function automatic logic is_digit(input byte_t c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input byte_t c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic byte_t upcase(input byte_t c);
    return ((c >= "a") && (c <= "z")) ? byte_t'(c - 8'd32) : c;
  endfunction

endpackage

// ===== rtl/accc_range_lane.sv =====
// One address lane: tests the address against one inclusive military range.
// Depends on no other file.
module accc_range_lane (
  input  logic [23:0] addr,
  input  logic [23:0] lo,
  input  logic [23:0] hi,
  output logic        hit
);

  // Both bounds are inclusive.
  assign hit = (addr >= lo) && (addr <= hi);

endmodule

// ===== rtl/accc_tag_lane.sv =====
// One prefix lane: case-insensitive match of one military prefix followed by a digit.
// Depends on accc_pkg for the byte type and character helpers.
module accc_tag_lane (
  input  accc_pkg::cs_t                    cs,
  input  logic [8*accc_pkg::TagMax-1:0]    tag,
  input  logic [2:0]                       tag_len,
  output logic                             hit
);

  logic prefix_ok;
  logic digit_ok;

  // Every character inside the prefix must match; the one just after it must be a digit.
  always_comb begin
    prefix_ok = 1'b1;
    digit_ok  = 1'b0;
    for (int k = 0; k < accc_pkg::TagMax; k++) begin
      if ((3'(k) < tag_len) &&
          (accc_pkg::upcase(cs[k]) != tag[8*(accc_pkg::TagMax-1-k) +: 8])) begin
        prefix_ok = 1'b0;
      end
    end
    for (int k = 0; k < accc_pkg::CsLen; k++) begin
      if (3'(k) == tag_len) begin
        digit_ok = accc_pkg::is_digit(cs[k]);
      end
    end
  end

  assign hit = prefix_ok && digit_ok;

endmodule

// ===== rtl/accc_merge.sv =====
// Merging stage: folds the lane hit flags of one item into its category by priority.
// Depends on accc_pkg.
module accc_merge (
  input  accc_pkg::hits_t hits,
  output accc_pkg::cat_t  category
);

  // Military wins over commercial, which wins over general aviation.
  always_comb begin
    if ((|hits.range_hit) || (|hits.tag_hit)) begin
      category = accc_pkg::CAT_MILITARY;
    end else if (hits.airline) begin
      category = accc_pkg::CAT_COMMERCIAL;
    end else if (hits.regn) begin
      category = accc_pkg::CAT_GENERAL;
    end else begin
      category = accc_pkg::CAT_UNKNOWN;
    end
  end

endmodule

// ===== rtl/aircraft_category_classifier_unit.sv =====
// Aircraft category classifier: an address and a six-byte callsign in, one category out.
// Uses accc_pkg, accc_range_lane, accc_tag_lane and accc_merge.
//
// Usage:
//   Input beats arrive on in_tvalid/in_tready/in_tdata, carrying the 24-bit address
//   and six callsign bytes. Each input beat yields exactly one output beat on
//   out_tvalid/out_tready/out_tdata, whose low two bits hold the category
//   (0 military, 1 commercial, 2 general aviation, 3 unknown).
//   The beat passes two register stages: the lane stage, loaded at the accepting edge
//   with the flags of the five address lanes, twenty prefix lanes and the airline and
//   registration tests, and the output register after the merge. out_tvalid rises
//   once the beat moves into the output register. Throughput is one beat per cycle
//   unless the receiver stalls; every test is a fixed compare on the beat itself.
//   When the receiver stalls, the result waits in the output register and one more
//   beat is still taken into the lane stage; in_tready falls only when both are full.
//   Reset empties both stages; no other state is kept and no configuration exists.
module aircraft_category_classifier_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Fields from bit 0: icao_address[23:0], char_0, char_1, char_2, char_3, char_4, char_5.
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // Fields from bit 0: category[1:0], zero padding[7:2].
  output logic [7:0]  out_tdata
);

  logic [23:0]     addr;
  accc_pkg::byte_t raw [accc_pkg::CsLen];
  accc_pkg::cs_t   cs;
  accc_pkg::hits_t hits_nxt;
  accc_pkg::hits_t s1_hits_r;
  logic            s1_valid_r;
  logic            adv1;
  logic            adv2;
  accc_pkg::cat_t  cat_nxt;
  accc_pkg::cat_t  out_cat_r;
  logic            out_valid_r;

  assign addr = in_tdata[23:0];

  // Bytes at or after the first zero byte count as zero.
  always_comb begin
    logic ended;
    ended = 1'b0;
    for (int i = 0; i < accc_pkg::CsLen; i++) begin
      raw[i] = in_tdata[24 + 8*i +: 8];
      if (raw[i] == 8'd0) begin
        ended = 1'b1;
      end
      cs[i] = ended ? 8'd0 : raw[i];
    end
  end

  // Address lanes.
  for (genvar r = 0; r < accc_pkg::NRanges; r++) begin : g_range
    accc_range_lane u_range (
      .addr (addr),
      .lo   (accc_pkg::RANGE_LO[r]),
      .hi   (accc_pkg::RANGE_HI[r]),
      .hit  (hits_nxt.range_hit[r])
    );
  end

  // Prefix lanes.
  for (genvar t = 0; t < accc_pkg::NTags; t++) begin : g_tag
    accc_tag_lane u_tag (
      .cs      (cs),
      .tag     (accc_pkg::TAG_TEXT[t]),
      .tag_len (accc_pkg::TAG_LEN[t]),
      .hit     (hits_nxt.tag_hit[t])
    );
  end

  // Airline and registration forms, upper-case letters matched as written.
  assign hits_nxt.airline = accc_pkg::is_letter(cs[0]) && accc_pkg::is_letter(cs[1]) &&
                            accc_pkg::is_letter(cs[2]) && accc_pkg::is_digit(cs[3]);
  assign hits_nxt.regn = ((cs[0] == "N") && accc_pkg::is_digit(cs[1])) ||
                         ((cs[0] == "E") && (cs[1] == "I") && accc_pkg::is_letter(cs[2])) ||
                         (((cs[0] == "G") || (cs[0] == "D") || (cs[0] == "F") ||
                           ((cs[0] == "C") && (cs[1] != "F"))) &&
                          accc_pkg::is_letter(cs[1]) && accc_pkg::is_letter(cs[2]));

  // Pipeline advance: each stage moves when the one after it has room.
  assign adv2      = !out_valid_r || out_tready;
  assign adv1      = !s1_valid_r || adv2;
  assign in_tready = adv1;

  accc_merge u_merge (
    .hits     (s1_hits_r),
    .category (cat_nxt)
  );

  // Lane stage and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid_r <= in_tvalid;
      end
      if (adv2) begin
        out_valid_r <= s1_valid_r;
      end
    end
    if (adv1 && in_tvalid) begin
      s1_hits_r <= hits_nxt;
    end
    if (adv2 && s1_valid_r) begin
      out_cat_r <= cat_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_cat_r};

  // A beat in the lane stage stays there while the output register is blocked.
  a_s1_hold : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv2 |=> s1_valid_r)
    else $error("lane stage beat lost during output stall");

  // Back-pressure only when both stages hold a beat.
  a_ready_full : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r))
    else $error("input refused with room in the pipeline");

  // An accepted beat reaches the lane stage.
  a_accept_fill : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> s1_valid_r)
    else $error("accepted beat did not enter the lane stage");

  // An address range hit comes out as military.
  a_range_mil : assert property (@(posedge clk) disable iff (!rst_n)
    adv2 && s1_valid_r && (|s1_hits_r.range_hit) |=>
      out_tdata[1:0] == accc_pkg::CAT_MILITARY)
    else $error("range hit not reported as military");

endmodule
